// ===== rtl/arms_pkg.sv =====
// ----------------------------------------------------------------------------
// arms_pkg
// Shared types and codes for the analog run-mode sequencer.
// ----------------------------------------------------------------------------
package arms_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned TICK_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IC_TICKS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OP_TICKS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD_POLICY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTHALT_POLICY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE       = 3'd4;

  // sync mode codes
  localparam logic [1:0] SYNC_NONE   = 2'd0;
  localparam logic [1:0] SYNC_MASTER = 2'd1;
  localparam logic [1:0] SYNC_SLAVE  = 2'd2;

  // command codes
  localparam logic [2:0] CMD_NONE         = 3'd0;
  localparam logic [2:0] CMD_FORCE_IDLE   = 3'd1;
  localparam logic [2:0] CMD_FORCE_IC     = 3'd2;
  localparam logic [2:0] CMD_FORCE_OP     = 3'd3;
  localparam logic [2:0] CMD_FORCE_HALT   = 3'd4;
  localparam logic [2:0] CMD_FORCE_END    = 3'd5;

  // reported mode codes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_IC       = 3'd1;
  localparam logic [2:0] MODE_OP       = 3'd2;
  localparam logic [2:0] MODE_EXTHALT  = 3'd3;
  localparam logic [2:0] MODE_END      = 3'd4;
  localparam logic [2:0] MODE_OVERLOAD = 3'd5;

  localparam logic [TICK_W-1:0] TICKS_RESET = 32'd480;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_IC       = 6'b000010,
    PH_OP       = 6'b000100,
    PH_EXTHALT  = 6'b001000,
    PH_END      = 6'b010000,
    PH_OVERLOAD = 6'b100000
  } phase_t;

  function automatic logic [2:0] mode_code(input phase_t ph);
    logic [2:0] code;
    code = MODE_IDLE;
    unique case (ph)
      PH_IDLE:     code = MODE_IDLE;
      PH_IC:       code = MODE_IC;
      PH_OP:       code = MODE_OP;
      PH_EXTHALT:  code = MODE_EXTHALT;
      PH_END:      code = MODE_END;
      PH_OVERLOAD: code = MODE_OVERLOAD;
      default:     code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/arms_in_if.sv =====
// ----------------------------------------------------------------------------
// arms_in_if
// Tick channel into the sequencer: command and status lines per tick.
// ----------------------------------------------------------------------------
interface arms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic       overload;
  logic       ext_halt;
  logic       sync_match;

  modport source (output valid, cmd, overload, ext_halt, sync_match, input ready);
  modport sink (input valid, cmd, overload, ext_halt, sync_match, output ready);
endinterface

// ===== rtl/arms_out_if.sv =====
// ----------------------------------------------------------------------------
// arms_out_if
// Result channel out of the sequencer: mode, drive lines and op tick count.
// ----------------------------------------------------------------------------
interface arms_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode_state;
  logic        ic_drive;
  logic        op_drive;
  logic        done_res;
  logic [31:0] op_elapsed;

  modport source (output valid, mode_state, ic_drive, op_drive, done_res, op_elapsed,
                  input ready);
  modport sink (input valid, mode_state, ic_drive, op_drive, done_res, op_elapsed,
                output ready);
endinterface

// ===== rtl/analog_run_mode_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// analog_run_mode_sequencer_core
// Run sequencer for an analog computer: idle, ic, op, halt, end, overload.
//
// in_ch carries one tick per transfer: cmd, overload, ext_halt, sync_match.
// out_ch returns one result per tick: mode_state, ic/op drive lines,
// done_res and the wrapping count of op ticks, all after the tick's update.
// Registers are written through cfg_we/cfg_index/cfg_data while idle; the
// user must ensure it, as the block does not. Results are valid in the
// cycle after the input transfer, one tick per cycle while out_ch.ready is
// high. The phase update, timer compare and result register load all happen
// in the single cycle of the input transfer. The result register is the
// only buffer: while a result waits, in_ch.ready follows out_ch.ready, so a
// stalled receiver stalls the tick source and no tick is lost or repeated.
// Reset puts the phase in idle, clears both counters, drops out_ch.valid
// and loads the register defaults (480 ticks for ic and op, policies and
// sync mode zero).
// ----------------------------------------------------------------------------
module analog_run_mode_sequencer_core
  import arms_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  arms_in_if.sink               in_ch,
  arms_out_if.source            out_ch
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [TICK_W-1:0] ic_ticks;
  logic [TICK_W-1:0] op_ticks;
  logic              overload_policy;
  logic              exthalt_policy;
  logic [1:0]        sync_mode;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [COUNT_WIDTH-1:0] phase_count;
  logic [COUNT_WIDTH-1:0] phase_count_next;
  logic [TICK_W-1:0]      op_tick_total;
  logic [TICK_W-1:0]      op_tick_total_next;

  logic                   out_valid;
  logic                   accept;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [TICK_W-1:0]      limit;
  logic [TICK_W-1:0]      target;
  logic                   time_up;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ic_ticks        <= TICKS_RESET;
      op_ticks        <= TICKS_RESET;
      overload_policy <= 1'b0;
      exthalt_policy  <= 1'b0;
      sync_mode       <= SYNC_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IC_TICKS:        ic_ticks        <= cfg_data[TICK_W-1:0];
        REG_OP_TICKS:        op_ticks        <= cfg_data[TICK_W-1:0];
        REG_OVERLOAD_POLICY: overload_policy <= cfg_data[0];
        REG_EXTHALT_POLICY:  exthalt_policy  <= cfg_data[0];
        REG_SYNC_MODE:       sync_mode       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // phase timer
  assign count_inc = (phase_count == COUNT_MAX) ? phase_count
                                                : phase_count + COUNT_WIDTH'(1);
  assign limit   = (phase == PH_IC) ? ic_ticks : op_ticks;
  assign target  = (limit == '0) ? TICK_W'(1) : limit;
  assign time_up = CMP_W'(count_inc) >= CMP_W'(target);

  assign op_tick_total_next = (phase == PH_OP) ? op_tick_total + TICK_W'(1)
                                               : op_tick_total;

  always_comb begin
    phase_next       = phase;
    phase_count_next = phase_count;
    case (in_ch.cmd)
      CMD_FORCE_IDLE: begin
        phase_next       = PH_IDLE;
        phase_count_next = '0;
      end
      CMD_FORCE_IC: begin
        phase_next       = PH_IC;
        phase_count_next = '0;
      end
      CMD_FORCE_OP: begin
        phase_next       = PH_OP;
        phase_count_next = '0;
      end
      CMD_FORCE_HALT: begin
        phase_next       = PH_EXTHALT;
        phase_count_next = '0;
      end
      CMD_FORCE_END: begin
        phase_next       = PH_END;
        phase_count_next = '0;
      end
      default: begin
        unique case (phase)
          PH_IDLE: begin
            if (sync_mode != SYNC_NONE && in_ch.sync_match) begin
              phase_next       = PH_IC;
              phase_count_next = '0;
            end
          end
          PH_IC: begin
            phase_count_next = count_inc;
            if (time_up) begin
              phase_next       = PH_OP;
              phase_count_next = '0;
            end
          end
          PH_OP: begin
            phase_count_next = count_inc;
            priority if (time_up) begin
              phase_next       = PH_END;
              phase_count_next = '0;
            end else if (in_ch.overload && overload_policy) begin
              phase_next       = PH_OVERLOAD;
              phase_count_next = '0;
            end else if (in_ch.ext_halt && exthalt_policy) begin
              phase_next       = PH_EXTHALT;
              phase_count_next = '0;
            end else begin
              phase_next       = PH_OP;
            end
          end
          PH_EXTHALT: begin
            if (!in_ch.ext_halt) begin
              phase_next       = PH_OP;
              phase_count_next = '0;
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_count   <= '0;
      op_tick_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        phase_count   <= phase_count_next;
        op_tick_total <= op_tick_total_next;
        out_valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.mode_state <= mode_code(phase_next);
      out_ch.ic_drive   <= (phase_next == PH_IC);
      out_ch.op_drive   <= (phase_next == PH_OP);
      out_ch.done_res   <= (phase_next == PH_END) || (phase_next == PH_OVERLOAD);
      out_ch.op_elapsed <= op_tick_total_next;
    end
  end

  assign out_ch.valid = out_valid;

  a_done_matches_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_ch.done_res ==
      (out_ch.mode_state == MODE_END || out_ch.mode_state == MODE_OVERLOAD))
    else $error("done_res disagrees with mode_state");

  a_force_idle: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.cmd == CMD_FORCE_IDLE |=> phase == PH_IDLE && phase_count == '0)
    else $error("force idle did not take effect");

  a_op_tick_count: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_OP |=> op_tick_total == $past(op_tick_total) + TICK_W'(1))
    else $error("op tick total did not advance");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.mode_state == mode_code(phase) && out_ch.op_elapsed == op_tick_total)
    else $error("result register out of step with state");

endmodule

// ===== test/tb_analog_run_mode_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// tb_analog_run_mode_sequencer_core
// Drives per-tick command and status items into the run-mode sequencer and
// checks every returned status against a cycle-free phase predictor: mode,
// drive lines, done flag and the op tick count. Covers all commands, unused
// command and sync codes, zero and maximum tick counts, overload and
// external-halt policies, and random runs with sender gaps and receiver
// stalls, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_analog_run_mode_sequencer_core;
  import arms_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned RUN_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS  = 85;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam logic [1:0] SYNC_SPARE  = 2'd3;

  localparam logic POLICY_IGNORE = 1'b0;
  localparam logic POLICY_ACT    = 1'b1;

  localparam logic [31:0] TICKS_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  mode_state;
    logic        ic_drive;
    logic        op_drive;
    logic        done_res;
    logic [31:0] op_elapsed;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  arms_in_if  in_ch ();
  arms_out_if out_ch ();

  analog_run_mode_sequencer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer model state and register copy
  logic [2:0]  seq_phase     = MODE_IDLE;
  logic [31:0] seq_count     = '0;
  logic [31:0] seq_op_total  = '0;
  logic [31:0] run_ic_ticks  = TICKS_RESET;
  logic [31:0] run_op_ticks  = TICKS_RESET;
  logic        ovl_stop      = POLICY_IGNORE;
  logic        halt_pause    = POLICY_IGNORE;
  logic [1:0]  sync_sel      = SYNC_NONE;

  status_t     pending_status[$];
  int unsigned error_count   = 0;
  int unsigned hold_requests = 0;
  int unsigned burst_left    = 0;
  int unsigned cycle_count   = 0;

  function automatic void enter_phase(input logic [2:0] next);
    seq_phase = next;
    seq_count = '0;
  endfunction

  function automatic logic phase_time_up(input logic [31:0] limit);
    logic [32:0] target;
    target = (limit == '0) ? 33'd1 : {1'b0, limit};
    if (seq_count != TICKS_MAX) seq_count = seq_count + 32'd1;
    return {1'b0, seq_count} >= target;
  endfunction

  function automatic status_t sequencer_step(input logic [2:0] cmd, input logic ovl,
                                             input logic halt, input logic sync);
    status_t st;
    if (seq_phase == MODE_OP) seq_op_total = seq_op_total + 32'd1;
    case (cmd)
      CMD_FORCE_IDLE: enter_phase(MODE_IDLE);
      CMD_FORCE_IC:   enter_phase(MODE_IC);
      CMD_FORCE_OP:   enter_phase(MODE_OP);
      CMD_FORCE_HALT: enter_phase(MODE_EXTHALT);
      CMD_FORCE_END:  enter_phase(MODE_END);
      default: begin
        case (seq_phase)
          MODE_IDLE: begin
            if (sync_sel != SYNC_NONE && sync) enter_phase(MODE_IC);
          end
          MODE_IC: begin
            if (phase_time_up(run_ic_ticks)) enter_phase(MODE_OP);
          end
          MODE_OP: begin
            if (phase_time_up(run_op_ticks)) enter_phase(MODE_END);
            else if (ovl && ovl_stop) enter_phase(MODE_OVERLOAD);
            else if (halt && halt_pause) enter_phase(MODE_EXTHALT);
          end
          MODE_EXTHALT: begin
            if (!halt) enter_phase(MODE_OP);
          end
          default: ;
        endcase
      end
    endcase
    st.mode_state = seq_phase;
    st.ic_drive   = (seq_phase == MODE_IC);
    st.op_drive   = (seq_phase == MODE_OP);
    st.done_res   = (seq_phase == MODE_END) || (seq_phase == MODE_OVERLOAD);
    st.op_elapsed = seq_op_total;
    return st;
  endfunction

  // result check first, then prediction for the tick taken at this edge
  always @(posedge clk) begin
    status_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_status.size() == 0) begin
          $error("unexpected result transfer: mode_state %0d", out_ch.mode_state);
          error_count++;
        end else begin
          want = pending_status.pop_front();
          if (out_ch.mode_state !== want.mode_state) begin
            $error("mode_state: expected %0d, got %0d", want.mode_state, out_ch.mode_state);
            error_count++;
          end
          if (out_ch.ic_drive !== want.ic_drive) begin
            $error("ic_drive: expected %0d, got %0d", want.ic_drive, out_ch.ic_drive);
            error_count++;
          end
          if (out_ch.op_drive !== want.op_drive) begin
            $error("op_drive: expected %0d, got %0d", want.op_drive, out_ch.op_drive);
            error_count++;
          end
          if (out_ch.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, out_ch.done_res);
            error_count++;
          end
          if (out_ch.op_elapsed !== want.op_elapsed) begin
            $error("op_elapsed: expected %0d, got %0d", want.op_elapsed, out_ch.op_elapsed);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_status.push_back(sequencer_step(in_ch.cmd, in_ch.overload,
                                                in_ch.ext_halt, in_ch.sync_match));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: rotating stall pattern, plus long hold-offs on request
  initial begin
    int unsigned pos;
    int unsigned hold_left;
    int unsigned holds_seen;
    logic [15:0] pattern;
    out_ch.ready = 1'b0;
    pos = 0;
    hold_left = 0;
    holds_seen = 0;
    pattern = 16'hFFFF;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (pos == 0 && $urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 3))
            0: pattern = 16'hFFFF;
            1: pattern = 16'($urandom);
            2: pattern = 16'($urandom | $urandom);
            default: pattern = 16'($urandom & $urandom) | 16'h0001;
          endcase
        end
        out_ch.ready <= pattern[pos];
        pos = (pos + 1) % 16;
      end
    end
  end

  // one tick transfer; called and returning at a rising edge
  task automatic send_tick(input logic [2:0] cmd, input logic ovl, input logic halt,
                           input logic sync);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(8, 20);
      else gap = $urandom_range(1, 3);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.overload   <= ovl;
    in_ch.ext_halt   <= halt;
    in_ch.sync_match <= sync;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_IC_TICKS:        run_ic_ticks = val;
      REG_OP_TICKS:        run_op_ticks = val;
      REG_OVERLOAD_POLICY: ovl_stop     = val[0];
      REG_EXTHALT_POLICY:  halt_pause   = val[0];
      REG_SYNC_MODE:       sync_sel     = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] ic, input logic [31:0] op, input logic ovl,
                            input logic halt, input logic [1:0] sync);
    write_reg(REG_IC_TICKS, ic);
    write_reg(REG_OP_TICKS, op);
    write_reg(REG_OVERLOAD_POLICY, {31'd0, ovl});
    write_reg(REG_EXTHALT_POLICY, {31'd0, halt});
    write_reg(REG_SYNC_MODE, {30'd0, sync});
    cfg_we <= 1'b0;
  endtask

  // reset defaults while the receiver holds off and the block backs up
  task automatic test_backpressure_defaults();
    hold_requests++;
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b1);
    send_tick(CMD_FORCE_IC, 1'b0, 1'b0, 1'b0);
    repeat (22)
      send_tick(CMD_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    drain_results();
  endtask

  // sync start, zero ic count, time-over priority, unused codes, all commands
  task automatic test_sync_and_commands();
    set_config(32'd0, 32'd3, POLICY_ACT, POLICY_IGNORE, SYNC_SPARE);
    send_tick(CMD_FORCE_IDLE, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b1);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b1, 1'b0);
    send_tick(CMD_SPARE_6, 1'b0, 1'b1, 1'b1);
    send_tick(CMD_SPARE_7, 1'b1, 1'b1, 1'b1);
    send_tick(CMD_NONE, 1'b1, 1'b1, 1'b1);
    send_tick(CMD_FORCE_OP, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b1, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b1);
    send_tick(CMD_FORCE_HALT, 1'b0, 1'b1, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b1, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_FORCE_OP, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_FORCE_IC, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_FORCE_END, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_FORCE_IDLE, 1'b1, 1'b1, 1'b1);
    drain_results();
  endtask

  // pause and restart with full time, ignored overload, endless op count
  task automatic test_halt_policy();
    set_config(32'd1, TICKS_MAX, POLICY_IGNORE, POLICY_ACT, SYNC_NONE);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b1);
    send_tick(CMD_FORCE_IC, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b1, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b1, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b1, 1'b1, 1'b0);
    send_tick(CMD_FORCE_IDLE, 1'b0, 1'b0, 1'b0);
    drain_results();
  endtask

  // maximum ic count never runs out; single-tick op
  task automatic test_long_counts();
    set_config(TICKS_MAX, 32'd1, POLICY_ACT, POLICY_ACT, SYNC_MASTER);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b1);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b0, 1'b0, 1'b1);
    send_tick(CMD_FORCE_OP, 1'b0, 1'b0, 1'b0);
    send_tick(CMD_NONE, 1'b1, 1'b1, 1'b0);
    send_tick(CMD_FORCE_IDLE, 1'b0, 1'b0, 1'b0);
    drain_results();
  endtask

  function automatic logic [31:0] pick_ticks();
    case ($urandom_range(0, 11))
      0: return 32'd0;
      1: return 32'd1;
      2: return TICKS_MAX;
      3: return $urandom_range(10, 40);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic test_random_runs();
    logic [2:0] cmd;
    logic       noisy;
    for (int p = 0; p < RUN_PHASES; p++) begin
      set_config(pick_ticks(), pick_ticks(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      noisy = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, noisy ? 2 : 9) == 0) cmd = 3'($urandom_range(1, 7));
        else cmd = CMD_NONE;
        send_tick(cmd, $urandom_range(0, noisy ? 1 : 9) == 0,
                  $urandom_range(0, noisy ? 1 : 6) == 0, $urandom_range(0, 3) == 0);
      end
      drain_results();
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_NONE;
    in_ch.overload   = 1'b0;
    in_ch.ext_halt   = 1'b0;
    in_ch.sync_match = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_backpressure_defaults();
    test_sync_and_commands();
    test_halt_policy();
    test_long_counts();
    test_random_runs();
    drain_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== analog_run_mode_sequencer_core.f =====
rtl/arms_pkg.sv
rtl/arms_in_if.sv
rtl/arms_out_if.sv
rtl/analog_run_mode_sequencer_core.sv
test/tb_analog_run_mode_sequencer_core.sv
